/* design/hlr_pkg.sv */
// Shared types and constants for the hop-limited reachability unit.
package hlr_pkg;

    localparam int VERTEX_W         = 5;
    localparam int LIMIT_W          = 8;
    localparam int NUM_VERTICES_DEF = 32;

    typedef enum logic [0:0] {
        OP_ADD_EDGE = 1'b0,
        OP_QUERY    = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_REPORT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic edge_wr;
        logic query_load;
        logic step;
        logic result_load;
    } ctl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic expand_done;
    } dp_status_t;

endpackage

/* design/hlr_if.sv */
// Handshake interfaces for the command and response channels.
interface hlr_cmd_if;
    logic                              valid;
    logic                              ready;
    hlr_pkg::op_t                      operation;
    logic [hlr_pkg::VERTEX_W-1:0]      vertex_a;
    logic [hlr_pkg::VERTEX_W-1:0]      vertex_b;
    logic [hlr_pkg::LIMIT_W-1:0]       depth_limit;

    modport source (output valid, operation, vertex_a, vertex_b, depth_limit, input ready);
    modport sink   (input valid, operation, vertex_a, vertex_b, depth_limit, output ready);
endinterface

interface hlr_rsp_if;
    logic valid;
    logic ready;
    logic path_found;

    modport source (output valid, path_found, input ready);
    modport sink   (input valid, path_found, output ready);
endinterface

/* design/hlr_datapath.sv */
// Adjacency matrix, reach set expansion, hop counting and result register.
module hlr_datapath #(
    parameter int NUM_VERTICES = hlr_pkg::NUM_VERTICES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  hlr_pkg::ctl_cmd_t             ctl,
    input  logic [hlr_pkg::VERTEX_W-1:0]  vertex_a,
    input  logic [hlr_pkg::VERTEX_W-1:0]  vertex_b,
    input  logic [hlr_pkg::LIMIT_W-1:0]   depth_limit,
    output hlr_pkg::dp_status_t           status,
    output logic                          path_found
);

    localparam int HOP_W = $clog2(NUM_VERTICES);

    logic [NUM_VERTICES-1:0] adj_reg [NUM_VERTICES];
    logic [NUM_VERTICES-1:0] reach_reg;
    logic [NUM_VERTICES-1:0] reach_next;
    logic [NUM_VERTICES-1:0] goal_hot_reg;
    logic [HOP_W-1:0]        hop_reg;
    logic [HOP_W-1:0]        steps_reg;
    logic [HOP_W-1:0]        steps_next;
    logic                    oor_reg;
    logic                    same_reg;
    logic                    path_found_reg;
    logic                    path_found_next;

    logic [NUM_VERTICES-1:0] a_hot;
    logic [NUM_VERTICES-1:0] b_hot;
    logic                    in_range;

    // A vertex number at or above the vertex count decodes to all zeros
    assign a_hot    = NUM_VERTICES'(1) << vertex_a;
    assign b_hot    = NUM_VERTICES'(1) << vertex_b;
    assign in_range = (|a_hot) && (|b_hot);

    assign steps_next = (depth_limit > hlr_pkg::LIMIT_W'(NUM_VERTICES - 1))
                        ? HOP_W'(NUM_VERTICES - 1) : HOP_W'(depth_limit);

    // Matrix is symmetric, so row j doubles as column j
    for (genvar j = 0; j < NUM_VERTICES; j++) begin : g_row
        assign reach_next[j] = reach_reg[j] | (|(adj_reg[j] & reach_reg));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                adj_reg[j] <= '0;
            end
            else if (ctl.edge_wr && in_range)
            begin
                adj_reg[j] <= adj_reg[j] | (a_hot[j] ? b_hot : '0) | (b_hot[j] ? a_hot : '0);
            end
        end
    end

    // Done when a vertex was out of range, the hop budget is spent or the reach set stopped growing
    assign status.expand_done = oor_reg || (hop_reg == steps_reg) || (reach_next == reach_reg);

    assign path_found_next = oor_reg ? same_reg : (|(reach_reg & goal_hot_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reach_reg <= '0;
            hop_reg   <= '0;
            steps_reg <= '0;
        end
        else if (ctl.query_load)
        begin
            reach_reg <= in_range ? a_hot : '0;
            hop_reg   <= '0;
            steps_reg <= steps_next;
        end
        else if (ctl.step)
        begin
            reach_reg <= reach_next;
            hop_reg   <= hop_reg + HOP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.query_load)
        begin
            goal_hot_reg <= b_hot;
            oor_reg      <= !in_range;
            same_reg     <= (vertex_a == vertex_b);
        end
        if (ctl.result_load)
        begin
            path_found_reg <= path_found_next;
        end
    end

    assign path_found = path_found_reg;

    a_hop_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hop_reg <= steps_reg)
        else $error("hop counter ran past its step budget");

    a_reach_grows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.step |=> ((reach_reg & $past(reach_reg)) == $past(reach_reg)))
        else $error("reach set lost a vertex during expansion");

endmodule

/* design/hlr_ctrl.sv */
// Sequencer for edge writes, query expansion and response handoff.
module hlr_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    input  hlr_pkg::op_t         operation,
    output logic                 cmd_ready,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  hlr_pkg::dp_status_t  status,
    output hlr_pkg::ctl_cmd_t    ctl
);

    hlr_pkg::state_t state_reg;
    hlr_pkg::state_t state_next;
    logic            rsp_valid_reg;
    logic            rsp_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hlr_pkg::ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        ctl            = '0;
        cmd_ready      = 1'b0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        case (state_reg)
            hlr_pkg::ST_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (operation == hlr_pkg::OP_QUERY)
                    begin
                        ctl.query_load = 1'b1;
                        state_next     = hlr_pkg::ST_EXPAND;
                    end
                    else
                    begin
                        ctl.edge_wr = 1'b1;
                    end
                end
            end
            hlr_pkg::ST_EXPAND:
            begin
                if (status.expand_done)
                begin
                    state_next = hlr_pkg::ST_REPORT;
                end
                else
                begin
                    ctl.step = 1'b1;
                end
            end
            hlr_pkg::ST_REPORT:
            begin
                // wait for the response register to free up
                if (!rsp_valid_reg || rsp_ready)
                begin
                    ctl.result_load = 1'b1;
                    rsp_valid_next  = 1'b1;
                    state_next      = hlr_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = hlr_pkg::ST_IDLE;
            end
        endcase
    end

    assign rsp_valid = rsp_valid_reg;

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.result_load |=> rsp_valid_reg)
        else $error("loaded result not presented");

    a_query_expands: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.query_load |=> (state_reg == hlr_pkg::ST_EXPAND))
        else $error("accepted query did not start expansion");

    a_report_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hlr_pkg::ST_REPORT && rsp_valid_reg && !rsp_ready)
        |=> (state_reg == hlr_pkg::ST_REPORT))
        else $error("result overwrote an untaken response word");

endmodule

/* design/hop_limited_reachability_unit.sv */
// Hop-limited reachability unit: an undirected graph as an adjacency bit matrix
// in flip-flops, cleared by reset, with reach-set expansion for queries. An
// add-edge word is taken while idle and gives no response. A query word gives
// one response word: the source is loaded, then up to min(depth_limit,
// NUM_VERTICES-1) expansion steps run, stopping early once the reach set no
// longer grows or a vertex is out of range; the controller then sees it done
// and loads the response register once that is free. Each expansion cycle adds
// one hop through an OR-reduction per matrix row. Edge words are still taken
// while a response word waits on the response channel.
module hop_limited_reachability_unit #(
    parameter int NUM_VERTICES = hlr_pkg::NUM_VERTICES_DEF
) (
    input  logic   clk,
    input  logic   rst_n,
    hlr_cmd_if.sink   cmd,
    hlr_rsp_if.source rsp
);

    hlr_pkg::ctl_cmd_t   ctl;
    hlr_pkg::dp_status_t status;

    hlr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .operation (cmd.operation),
        .cmd_ready (cmd.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .ctl       (ctl)
    );

    hlr_datapath #(
        .NUM_VERTICES (NUM_VERTICES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .vertex_a    (cmd.vertex_a),
        .vertex_b    (cmd.vertex_b),
        .depth_limit (cmd.depth_limit),
        .status      (status),
        .path_found  (rsp.path_found)
    );

endmodule

/* dv/hop_limited_reachability_unit_tb.sv */
// Self-checking testbench for the hop-limited reachability unit.
`timescale 1ns / 100ps

module hop_limited_reachability_unit_tb;

    localparam int NV          = hlr_pkg::NUM_VERTICES_DEF;
    localparam int USE_MODEL   = -1;
    localparam int DIR_N       = 23;
    localparam int RAND_N      = 1680;
    localparam int TAIL_N      = 200;
    localparam int LONG_HOLD   = 400;
    localparam int HOLD_AT_RSP = 300;
    localparam int SETTLE_CYC  = 40;

    typedef struct {
        hlr_pkg::op_t                 op;
        logic [hlr_pkg::VERTEX_W-1:0] va;
        logic [hlr_pkg::VERTEX_W-1:0] vb;
        logic [hlr_pkg::LIMIT_W-1:0]  lim;
        int                           want;
    } stim_row_t;

    logic clk;
    logic rst_n;

    hlr_cmd_if cmd_ch ();
    hlr_rsp_if rsp_ch ();

    hop_limited_reachability_unit dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch),
        .rsp   (rsp_ch)
    );

    // Graph as seen by the checker, plus the answers still owed by the block
    logic [NV-1:0] graph_rows [NV];
    logic          path_found_q [$];

    int  mismatches;
    int  edge_words;
    int  query_words;
    int  found_count;
    int  responses_seen;
    bit  quiet_tail;

    // Source equals goal, empty graph, repeated and self-loop edges, hop limits
    stim_row_t dir_rows [DIR_N] = '{
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd0,  8'd0,   1},
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd31, 8'd255, 0},
        '{hlr_pkg::OP_QUERY,    5'd31, 5'd31, 8'd255, 1},
        '{hlr_pkg::OP_QUERY,    5'd31, 5'd0,  8'd0,   0},
        '{hlr_pkg::OP_ADD_EDGE, 5'd0,  5'd1,  8'd0,   USE_MODEL},
        '{hlr_pkg::OP_ADD_EDGE, 5'd1,  5'd2,  8'd255, USE_MODEL},
        '{hlr_pkg::OP_ADD_EDGE, 5'd2,  5'd3,  8'd17,  USE_MODEL},
        '{hlr_pkg::OP_ADD_EDGE, 5'd2,  5'd1,  8'd0,   USE_MODEL},
        '{hlr_pkg::OP_ADD_EDGE, 5'd5,  5'd5,  8'd0,   USE_MODEL},
        '{hlr_pkg::OP_ADD_EDGE, 5'd30, 5'd31, 8'd0,   USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd3,  8'd2,   USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd3,  8'd3,   USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd3,  5'd0,  8'd255, USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd1,  8'd0,   0},
        '{hlr_pkg::OP_QUERY,    5'd5,  5'd6,  8'd255, USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd5,  5'd5,  8'd0,   1},
        '{hlr_pkg::OP_QUERY,    5'd31, 5'd30, 8'd1,   USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd31, 8'd255, USE_MODEL},
        '{hlr_pkg::OP_ADD_EDGE, 5'd3,  5'd30, 8'd0,   USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd31, 8'd5,   USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd0,  5'd31, 8'd4,   USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd31, 5'd0,  8'd31,  USE_MODEL},
        '{hlr_pkg::OP_QUERY,    5'd31, 5'd0,  8'd128, USE_MODEL}
    };

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Frontier expansion, one hop per step, capped at NV-1 steps
    function automatic logic reachable_within(logic [hlr_pkg::VERTEX_W-1:0] src,
                                              logic [hlr_pkg::VERTEX_W-1:0] dst,
                                              logic [hlr_pkg::LIMIT_W-1:0] lim);
        logic [NV-1:0] reach;
        logic [NV-1:0] grown;
        int            steps;
        if (src >= NV || dst >= NV)
            return src == dst;
        reach = '0;
        reach[src] = 1'b1;
        steps = (lim > NV - 1) ? NV - 1 : int'(lim);
        for (int s = 0; s < steps; s++)
        begin
            grown = reach;
            for (int v = 0; v < NV; v++)
                if (reach[v])
                    grown |= graph_rows[v];
            reach = grown;
        end
        return reach[dst];
    endfunction

    task automatic report_mismatch(string what, int want, int got);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s expected %0d got %0d", $time, what, want, got);
    endtask

    // Drive one word, wait for acceptance, then update the graph or owe an answer
    task automatic send_word(hlr_pkg::op_t op, logic [hlr_pkg::VERTEX_W-1:0] va,
                             logic [hlr_pkg::VERTEX_W-1:0] vb,
                             logic [hlr_pkg::LIMIT_W-1:0] lim, int want);
        logic owed;
        cmd_ch.valid       <= 1'b1;
        cmd_ch.operation   <= op;
        cmd_ch.vertex_a    <= va;
        cmd_ch.vertex_b    <= vb;
        cmd_ch.depth_limit <= lim;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
        if (op == hlr_pkg::OP_ADD_EDGE)
        begin
            if (va < NV && vb < NV)
            begin
                graph_rows[va][vb] = 1'b1;
                graph_rows[vb][va] = 1'b1;
            end
            edge_words++;
        end
        else
        begin
            owed = (want == USE_MODEL) ? reachable_within(va, vb, lim) : want[0];
            path_found_q = {path_found_q, owed};
            query_words++;
        end
    endtask

    // Command side: reset, directed table, random traffic, drain and verdict
    initial
    begin
        hlr_pkg::op_t                 op;
        logic [hlr_pkg::VERTEX_W-1:0] va;
        logic [hlr_pkg::VERTEX_W-1:0] vb;
        logic [hlr_pkg::LIMIT_W-1:0]  lim;
        bit                           idle_on;

        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.operation   <= hlr_pkg::OP_ADD_EDGE;
        cmd_ch.vertex_a    <= '0;
        cmd_ch.vertex_b    <= '0;
        cmd_ch.depth_limit <= '0;
        for (int v = 0; v < NV; v++)
            graph_rows[v] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_word(dir_rows[i].op, dir_rows[i].va, dir_rows[i].vb,
                      dir_rows[i].lim, dir_rows[i].want);

        idle_on = 1'b0;
        for (int i = 0; i < RAND_N; i++)
        begin
            if (i % 64 == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            quiet_tail = (i >= RAND_N - TAIL_N);

            // hold off mid-run until every answer owed has come back
            if (i == RAND_N / 2)
            begin
                cmd_ch.valid <= 1'b0;
                do
                    @(posedge clk);
                while (path_found_q.size() != 0);
            end

            // sparse edges keep the graph from collapsing into one hop
            op = ($urandom_range(0, 31) == 0) ? hlr_pkg::OP_ADD_EDGE : hlr_pkg::OP_QUERY;
            va = hlr_pkg::VERTEX_W'($urandom_range(0, 31));
            vb = ($urandom_range(0, 15) == 0) ? va
                                              : hlr_pkg::VERTEX_W'($urandom_range(0, 31));
            case ($urandom_range(0, 3))
                0, 1:    lim = hlr_pkg::LIMIT_W'($urandom_range(0, 6));
                2:       lim = hlr_pkg::LIMIT_W'($urandom_range(0, 40));
                default: lim = hlr_pkg::LIMIT_W'($urandom_range(0, 255));
            endcase
            send_word(op, va, vb, lim, USE_MODEL);

            if (!quiet_tail && idle_on && $urandom_range(0, 3) == 0)
            begin
                cmd_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
            end
        end
        cmd_ch.valid <= 1'b0;

        while (path_found_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);

        $display("Sent %0d edge words and %0d queries; %0d answered reachable, %0d not.",
                 edge_words, query_words, found_count, query_words - found_count);
        $display("Included a %0d-cycle response hold, a drain pause and random idle bursts.",
                 LONG_HOLD);
        if (mismatches == 0 && path_found_q.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // Response side: check each word, then decide ready for the next cycle
    initial
    begin
        int  hold_left;
        bit  stall_on;
        bit  long_hold_done;
        logic want;

        hold_left      = 0;
        stall_on       = 1'b1;
        long_hold_done = 1'b0;
        rsp_ch.ready  <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid && rsp_ch.ready)
            begin
                if (path_found_q.size() == 0)
                    report_mismatch("unexpected response word, path_found", -1,
                                    rsp_ch.path_found);
                else
                begin
                    want = path_found_q.pop_front();
                    if (rsp_ch.path_found !== want)
                        report_mismatch("path_found", want, rsp_ch.path_found);
                end
                if (rsp_ch.path_found === 1'b1)
                    found_count++;
                responses_seen++;
                if (responses_seen % 50 == 0)
                    stall_on = ($urandom_range(0, 2) != 0);
            end

            if (responses_seen == HOLD_AT_RSP && !long_hold_done)
            begin
                // long hold so the block backs up and stalls its command side
                long_hold_done = 1'b1;
                hold_left = LONG_HOLD;
            end

            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && stall_on && $urandom_range(0, 3) == 0)
            begin
                hold_left = $urandom_range(1, 3) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Timed out with %0d answers outstanding", path_found_q.size());
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* sim.f */
design/hlr_pkg.sv
design/hlr_if.sv
design/hlr_datapath.sv
design/hlr_ctrl.sv
design/hop_limited_reachability_unit.sv
dv/hop_limited_reachability_unit_tb.sv
